>>> src/farey_parents_finder_macros.svh
// assertion macros for the farey parents finder
`ifndef FAREY_PARENTS_FINDER_MACROS_SVH
`define FAREY_PARENTS_FINDER_MACROS_SVH
`ifndef SYNTHESIS
`define FPF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fpf assertion failed");
`define FPF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("fpf assertion failed");
`else
`define FPF_ASSERT(lbl, clk, rst_n, prop)
`define FPF_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> src/fpf_pkg.sv
`default_nettype none
package fpf_pkg;
    localparam int WIDTH = 31;
    localparam int CW    = WIDTH + 1;
    localparam int CNTW  = $clog2(WIDTH + 1);
endpackage
`default_nettype wire

>>> src/fpf_div.sv
`default_nettype none
`include "farey_parents_finder_macros.svh"
module fpf_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [fpf_pkg::WIDTH-1:0] i_dividend,
    input  wire logic [fpf_pkg::WIDTH-1:0] i_divisor,
    output logic                          o_done,
    output logic [fpf_pkg::WIDTH-1:0]      o_quot,
    output logic [fpf_pkg::WIDTH-1:0]      o_rem
);
    import fpf_pkg::*;

    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_quo, n_quo;
    logic [WIDTH-1:0] r_dvs;
    logic [CNTW-1:0]  r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [WIDTH:0]   w_trial;
    logic [WIDTH:0]   w_diff;

    // one restoring step per cycle, quotient bits shift in from the right
    always_comb begin
        w_trial = {r_rem, r_quo[WIDTH-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        if (!w_diff[WIDTH]) begin
            n_rem = w_diff[WIDTH-1:0];
            n_quo = {r_quo[WIDTH-2:0], 1'b1};
        end else begin
            n_rem = w_trial[WIDTH-1:0];
            n_quo = {r_quo[WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

    `FPF_ASSERT(a_start_idle, i_clk, i_rst_n, i_start |-> !r_busy)
    `FPF_ASSERT(a_divisor_nonzero, i_clk, i_rst_n, i_start |-> (i_divisor != '0))
    `FPF_ASSERT(a_rem_below_divisor, i_clk, i_rst_n, r_done |-> (r_rem < r_dvs))
endmodule
`default_nettype wire

>>> src/fpf_mul.sv
`default_nettype none
module fpf_mul (
    input  wire logic                      i_clk,
    input  wire logic [fpf_pkg::CW-1:0]     i_a,
    input  wire logic [fpf_pkg::CW-1:0]     i_b,
    output logic [2*fpf_pkg::CW-1:0]        o_prod
);
    import fpf_pkg::*;

    logic [2*CW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;
endmodule
`default_nettype wire

>>> src/farey_parents_finder.sv
// channel | valid       | ready        | payload
// input   | i_in_valid  | o_in_ready   | i_child_num_in, i_child_den_in
// output  | o_out_valid | i_out_ready  | o_bad_input, o_red_num .. o_right_den
//
// one item at a time; the input is ready only when the sequencer is idle
// each euclid step runs the shared radix-2 divider, then a multiply and a coefficient update
// worst case 44 steps, then two reductions by the gcd and a cross-multiply compare
// the result sits in an output register; a new item is taken while it waits
// synchronous active-low reset clears the sequencer and the output valid
`default_nettype none
`include "farey_parents_finder_macros.svh"
module farey_parents_finder (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [fpf_pkg::WIDTH-1:0] i_child_num_in,
    input  wire logic [fpf_pkg::WIDTH-1:0] i_child_den_in,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic                           o_bad_input,
    output logic [fpf_pkg::WIDTH-1:0]      o_red_num,
    output logic [fpf_pkg::WIDTH-1:0]      o_red_den,
    output logic [fpf_pkg::WIDTH-1:0]      o_left_num,
    output logic [fpf_pkg::WIDTH-1:0]      o_left_den,
    output logic [fpf_pkg::WIDTH-1:0]      o_right_num,
    output logic [fpf_pkg::WIDTH-1:0]      o_right_den
);
    import fpf_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_EUC  = 12'b0000_0000_0010,
        S_EDIV = 12'b0000_0000_0100,
        S_MX   = 12'b0000_0000_1000,
        S_MY   = 12'b0000_0001_0000,
        S_UPD  = 12'b0000_0010_0000,
        S_RP   = 12'b0000_0100_0000,
        S_RQ   = 12'b0000_1000_0000,
        S_CM1  = 12'b0001_0000_0000,
        S_CM2  = 12'b0010_0000_0000,
        S_CM3  = 12'b0100_0000_0000,
        S_FIN  = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic [WIDTH-1:0] r_p, r_q, r_a, r_b, r_quo, r_rem;
    logic [CW-1:0]    r_xa, r_ya, r_xb, r_yb, r_tx;
    logic [WIDTH-1:0] r_c, r_d, r_pr, r_qr, r_la, r_lb;
    logic [2*CW-1:0]  r_ad;
    logic             r_swap, r_bad;

    logic             r_out_valid, n_out_valid;
    logic             r_o_bad;
    logic [WIDTH-1:0] r_o_rn, r_o_rd, r_o_ln, r_o_ld, r_o_hn, r_o_hd;

    logic             w_accept;
    logic             w_in_bad;
    logic             w_div_start, w_div_done;
    logic [WIDTH-1:0] w_div_dvd, w_div_dvs, w_div_quot, w_div_rem;
    logic [CW-1:0]    w_mul_a, w_mul_b;
    logic [2*CW-1:0]  w_prod;
    logic [CW-1:0]    w_xneg, w_yneg;
    logic             w_load_out;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_in_bad   = (i_child_num_in == '0) || (i_child_num_in >= i_child_den_in);
    assign w_load_out = (r_state == S_FIN) && (!r_out_valid || i_out_ready);
    assign w_xneg     = -r_xb;
    assign w_yneg     = -r_yb;

    fpf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_rem)
    );

    fpf_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // divider operands and start
    always_comb begin
        w_div_start = 1'b0;
        w_div_dvd   = r_q;
        w_div_dvs   = r_b;
        case (r_state)
            S_EUC: begin
                w_div_start = 1'b1;
                if (r_a != '0) begin
                    w_div_dvd = r_b;
                    w_div_dvs = r_a;
                end else begin
                    w_div_dvd = r_p;
                    w_div_dvs = r_b;
                end
            end
            S_RP: begin
                w_div_start = w_div_done;
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    // multiplier operands
    always_comb begin
        case (r_state)
            S_MX: begin
                w_mul_a = {1'b0, r_quo};
                w_mul_b = r_xa;
            end
            S_MY: begin
                w_mul_a = {1'b0, r_quo};
                w_mul_b = r_ya;
            end
            S_CM1: begin
                w_mul_a = {1'b0, r_la};
                w_mul_b = {1'b0, r_d};
            end
            S_CM2: begin
                w_mul_a = {1'b0, r_c};
                w_mul_b = {1'b0, r_lb};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_in_bad ? S_FIN : S_EUC;
                end
            end
            S_EUC: begin
                n_state = (r_a != '0) ? S_EDIV : S_RP;
            end
            S_EDIV: begin
                if (w_div_done) begin
                    n_state = S_MX;
                end
            end
            S_MX:  n_state = S_MY;
            S_MY:  n_state = S_UPD;
            S_UPD: n_state = S_EUC;
            S_RP: begin
                if (w_div_done) begin
                    n_state = S_RQ;
                end
            end
            S_RQ: begin
                if (w_div_done) begin
                    n_state = S_CM1;
                end
            end
            S_CM1: n_state = S_CM2;
            S_CM2: n_state = S_CM3;
            S_CM3: n_state = S_FIN;
            S_FIN: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_p   <= i_child_num_in;
                    r_q   <= i_child_den_in;
                    r_a   <= i_child_num_in;
                    r_b   <= i_child_den_in;
                    r_xa  <= CW'(1);
                    r_ya  <= '0;
                    r_xb  <= '0;
                    r_yb  <= CW'(1);
                    r_bad <= w_in_bad;
                end
            end
            S_EUC: begin
                // loop end: b holds the gcd, coefficient magnitudes give one parent
                if (r_a == '0) begin
                    r_d <= r_xb[CW-1] ? w_xneg[WIDTH-1:0] : r_xb[WIDTH-1:0];
                    r_c <= r_yb[CW-1] ? w_yneg[WIDTH-1:0] : r_yb[WIDTH-1:0];
                end
            end
            S_EDIV: begin
                if (w_div_done) begin
                    r_quo <= w_div_quot;
                    r_rem <= w_div_rem;
                end
            end
            S_MY: begin
                r_tx <= r_xb - w_prod[CW-1:0];
            end
            S_UPD: begin
                r_b  <= r_a;
                r_a  <= r_rem;
                r_xb <= r_xa;
                r_yb <= r_ya;
                r_xa <= r_tx;
                r_ya <= r_yb - w_prod[CW-1:0];
            end
            S_RP: begin
                if (w_div_done) begin
                    r_pr <= w_div_quot;
                end
            end
            S_RQ: begin
                if (w_div_done) begin
                    r_qr <= w_div_quot;
                    r_la <= r_pr - r_c;
                    r_lb <= w_div_quot - r_d;
                end
            end
            S_CM2: begin
                r_ad <= w_prod;
            end
            S_CM3: begin
                r_swap <= (r_ad > w_prod);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_o_bad <= r_bad;
            if (r_bad) begin
                r_o_rn <= '0;
                r_o_rd <= '0;
                r_o_ln <= '0;
                r_o_ld <= '0;
                r_o_hn <= '0;
                r_o_hd <= '0;
            end else begin
                r_o_rn <= r_pr;
                r_o_rd <= r_qr;
                r_o_ln <= r_swap ? r_c  : r_la;
                r_o_ld <= r_swap ? r_d  : r_lb;
                r_o_hn <= r_swap ? r_la : r_c;
                r_o_hd <= r_swap ? r_lb : r_d;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_bad_input = r_o_bad;
    assign o_red_num   = r_o_rn;
    assign o_red_den   = r_o_rd;
    assign o_left_num  = r_o_ln;
    assign o_left_den  = r_o_ld;
    assign o_right_num = r_o_hn;
    assign o_right_den = r_o_hd;

    `FPF_ASSERT(a_accept_leaves_idle, i_clk, i_rst_n, w_accept |=> !o_in_ready)
    `FPF_ASSERT(a_parents_sum, i_clk, i_rst_n, (r_state == S_CM3) |-> ((r_la + r_c) == r_pr))
    `FPF_ASSERT(a_load_needs_room, i_clk, i_rst_n, w_load_out |-> (!r_out_valid || i_out_ready))
endmodule
`default_nettype wire
